// ----- rtl/deq_pkg.sv -----
package deq_pkg;

  // Command codes carried in the cmd field of an input beat.
  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } deq_cmd_t;

  // Status codes reported with every result beat.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } deq_status_t;

  // Value reported for both ends while the queue is empty.
  localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

  // Input beat.
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] push_value;
  } deq_in_t;

  // Result beat.
  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic [1:0]         status;
  } deq_out_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_right;  // push at the front: every value moves one cell back
    logic shift_left;   // pop at the front: every value moves one cell forward
    logic append;       // push at the back: the first free cell takes the value
  } deq_cell_ctl_t;

endpackage

// ----- rtl/deq_cell.sv -----
module deq_cell
  import deq_pkg::*;
#(
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  logic                  clk,
  input  deq_cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic signed [31:0]    push_value,
  input  logic signed [31:0]    left_val,
  input  logic signed [31:0]    right_val,
  output logic signed [31:0]    val_o,
  output logic signed [31:0]    tap_o
);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;
  logic               at_tail;
  logic               second_last;

  // This cell is the first free slot, or the one just ahead of the back value.
  assign at_tail     = (count == CNT_W'(INDEX));
  assign second_last = (count == CNT_W'(INDEX + 2));

  // Take the neighbor's value on a shift, or the new value when appended here.
  always_comb begin
    val_nxt = val_r;
    if (ctl.shift_right) begin
      val_nxt = left_val;
    end else if (ctl.shift_left) begin
      val_nxt = right_val;
    end else if (ctl.append && at_tail) begin
      val_nxt = push_value;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

  // Masked copy for the OR tree that finds the new back value on a back pop.
  assign tap_o = second_last ? val_r : '0;

endmodule

// ----- rtl/double_ended_queue_core.sv -----
// Bounded double-ended queue of 32-bit signed values held in a chain of
// DEPTH cells. Cell 0 always holds the front value; the back value sits in
// cell count-1 and is also kept in a shadow register.
// Input channel in_valid/in_ready/in_data carries one command per beat:
// push back, push front, pop front, pop back, or query. Every accepted beat
// yields exactly one result beat on out_valid/out_ready/out_data with the
// front and back values after the command (-1 when empty), the count, an
// empty flag and a status (pop on empty and push on full change nothing).
// The result of an accepted beat is registered and valid from the next
// clock edge on. Throughput is one beat per cycle while results are taken;
// the whole chain shifts at once, so no command ever waits on another.
// While the receiver stalls, the result stays in the output register and
// in_ready drops; it rises again in the cycle the result is taken.
// Synchronous active-low reset empties the queue and clears out_valid; the
// cell contents are not cleared and are never read before being written.
// entry_count carries the low five bits of the count.
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  deq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output deq_out_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic signed [31:0] back_r;
  logic signed [31:0] back_nxt;
  logic               out_valid_r;
  deq_out_t           out_data_r;
  deq_out_t           result;

  logic               in_fire;
  logic               full;
  logic               empty;
  deq_cell_ctl_t      ctl_raw;
  deq_cell_ctl_t      ctl;
  deq_status_t        status;
  logic signed [31:0] front_res;
  logic signed [31:0] second_last;

  logic signed [31:0] cell_val [DEPTH];
  logic signed [31:0] cell_tap [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  // Chain of cells; cell 0 takes the pushed value on a front push.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_val;
    logic signed [31:0] right_val;

    if (i == 0) begin : g_head
      assign left_val = in_data.push_value;
    end else begin : g_body
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    deq_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .push_value (in_data.push_value),
      .left_val   (left_val),
      .right_val  (right_val),
      .val_o      (cell_val[i]),
      .tap_o      (cell_tap[i])
    );
  end

  // OR of the masked taps gives the value just ahead of the back.
  always_comb begin
    second_last = '0;
    for (int i = 0; i < DEPTH; i++) begin
      second_last = second_last | cell_tap[i];
    end
  end

  // Command decode: chain controls, next count, next back and the front value.
  always_comb begin
    ctl_raw   = '0;
    count_nxt = count_r;
    back_nxt  = back_r;
    front_res = cell_val[0];
    status    = ST_DONE;
    case (in_data.cmd)
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_PUSH_FULL;
        end else begin
          ctl_raw.append = 1'b1;
          count_nxt      = count_r + 1'b1;
          back_nxt       = in_data.push_value;
          if (empty) begin
            front_res = in_data.push_value;
          end
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_PUSH_FULL;
        end else begin
          ctl_raw.shift_right = 1'b1;
          count_nxt           = count_r + 1'b1;
          front_res           = in_data.push_value;
          if (empty) begin
            back_nxt = in_data.push_value;
          end
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_POP_EMPTY;
        end else begin
          ctl_raw.shift_left = 1'b1;
          count_nxt          = count_r - 1'b1;
          front_res          = cell_val[1];
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = ST_POP_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          back_nxt  = second_last;
        end
      end
      default: begin
      end
    endcase
    ctl = in_fire ? ctl_raw : '0;
  end

  // Result beat as seen after the command.
  always_comb begin
    result.entry_count = 5'(count_nxt);
    result.is_empty    = (count_nxt == '0);
    result.status      = status;
    result.front_value = result.is_empty ? EMPTY_VALUE : front_res;
    result.back_value  = result.is_empty ? EMPTY_VALUE : back_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      back_r     <= back_nxt;
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never passes the number of cells.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  // An empty result reports -1 at both ends.
  a_empty_values : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.is_empty |->
      out_data_r.front_value == EMPTY_VALUE && out_data_r.back_value == EMPTY_VALUE)
    else $error("empty result with live end values");

  // A flagged command leaves the count as it was.
  a_flag_no_change : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (status == ST_POP_EMPTY || status == ST_PUSH_FULL) |=>
      count_r == $past(count_r))
    else $error("flagged command changed the count");

endmodule

// ----- verif/double_ended_queue_core_tb.sv -----
module double_ended_queue_core_tb
  import deq_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int RANDOM_BEATS = 924;
  localparam int CALM_AFTER = 880;
  localparam int LONG_STALL_AT = 300;
  localparam int LONG_STALL_CYCLES = 80;
  localparam int DRAIN_BEAT = 500;
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;

  // One queued stimulus beat; hold_for_drain makes the sender wait until
  // every earlier result has been taken before offering it.
  typedef struct {
    deq_in_t beat;
    bit      hold_for_drain;
  } stim_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  deq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  deq_out_t out_data;

  stim_t    pending_beats[$];
  deq_out_t expected_views[$];
  int       beats_total;
  int       beats_sent = 0;
  int       mismatches = 0;
  int       sender_gap = 0;

  // Shadow of the deque: ring of slots, front index and fill level.
  logic signed [31:0] ring_slots[DEPTH];
  logic [3:0]         ring_head = '0;
  logic [4:0]         ring_fill = '0;

  double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Applies one command to the shadow deque and returns the view after it.
  function automatic deq_out_t deque_step(deq_in_t beat);
    deq_out_t   view;
    logic [3:0] slot;
    view = '0;
    view.status = ST_DONE;
    case (beat.cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (ring_fill == DEPTH) begin
          view.status = ST_PUSH_FULL;
        end else if (beat.cmd == CMD_PUSH_BACK) begin
          slot = ring_head + ring_fill[3:0];
          ring_slots[slot] = beat.push_value;
          ring_fill = ring_fill + 5'd1;
        end else begin
          ring_head = ring_head - 4'd1;
          ring_slots[ring_head] = beat.push_value;
          ring_fill = ring_fill + 5'd1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (ring_fill == 0) begin
          view.status = ST_POP_EMPTY;
        end else begin
          if (beat.cmd == CMD_POP_FRONT) ring_head = ring_head + 4'd1;
          ring_fill = ring_fill - 5'd1;
        end
      end
      default: ;
    endcase
    if (ring_fill == 0) begin
      view.front_value = EMPTY_VALUE;
      view.back_value = EMPTY_VALUE;
    end else begin
      // A full ring has a zero low nibble, so the back lands just before the head.
      slot = ring_head + ring_fill[3:0] - 4'd1;
      view.front_value = ring_slots[ring_head];
      view.back_value = ring_slots[slot];
    end
    view.entry_count = ring_fill;
    view.is_empty = (ring_fill == 0);
    return view;
  endfunction

  task automatic add_beat(logic [2:0] op, logic signed [31:0] value, bit drain_first);
    stim_t s;
    s.beat.cmd = op;
    s.beat.push_value = value;
    s.hold_for_drain = drain_first;
    pending_beats.push_back(s);
  endtask

  task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
  endtask

  // Sender: offers queued beats, predicts each one as it is accepted.
  always @(posedge clk) begin : drive_beats
    bit    took;
    stim_t upcoming;
    took = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !took)) begin
      if (took) begin
        expected_views.push_back(deque_step(in_data));
        beats_sent++;
      end
      if (sender_gap > 0) begin
        sender_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_beats[0].hold_for_drain && (took || out_valid)) begin
        // Results still in flight; hold the next beat back.
        in_valid <= 1'b0;
      end else begin
        upcoming = pending_beats.pop_front();
        in_data <= upcoming.beat;
        in_valid <= 1'b1;
        if (beats_sent < CALM_AFTER && $urandom_range(0, 4) == 0)
          sender_gap = $urandom_range(1, 7);
      end
    end
  end

  // Receiver ready: short random stalls plus one long hold-off.
  always @(posedge clk) begin : drive_ready
    int  taken;
    int  stall_left;
    bit  long_stall_done;
    if (!rst_n) begin
      taken = 0;
      stall_left = 0;
      long_stall_done = 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) taken++;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!long_stall_done && taken >= LONG_STALL_AT) begin
        long_stall_done = 1'b1;
        stall_left = LONG_STALL_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (taken < CALM_AFTER && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker: compares each taken beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    deq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: %h", $realtime, out_data);
      end else begin
        want = expected_views.pop_front();
        if (out_data.front_value !== want.front_value)
          flag_field("front_value", want.front_value, out_data.front_value);
        if (out_data.back_value !== want.back_value)
          flag_field("back_value", want.back_value, out_data.back_value);
        if (out_data.entry_count !== want.entry_count)
          flag_field("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
        if (out_data.is_empty !== want.is_empty)
          flag_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
        if (out_data.status !== want.status)
          flag_field("status", 32'(want.status), 32'(out_data.status));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_test
    logic [2:0]         op;
    logic signed [31:0] value;
    int                 seg_left;
    int                 seg_mode;
    int                 push_pct;
    int                 pick;
    seg_left = 0;
    seg_mode = 0;

    // Directed: pops on empty, popping the last value from either end,
    // unused command codes, filling to full and pushes on full.
    add_beat(CMD_POP_FRONT, 32'sd5, 1'b0);
    add_beat(CMD_POP_BACK, -32'sd5, 1'b0);
    add_beat(CMD_PUSH_BACK, 32'sh7fffffff, 1'b0);
    add_beat(CMD_POP_FRONT, '0, 1'b0);
    add_beat(CMD_PUSH_FRONT, 32'sh80000000, 1'b0);
    add_beat(CMD_POP_BACK, '0, 1'b0);
    add_beat(CMD_QUERY, -32'sd1, 1'b0);
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      add_beat(3'(c), $urandom, 1'b0);
    for (int k = 0; k < DEPTH; k++) begin
      case (k)
        0: value = 32'sh7fffffff;
        1: value = 32'sh80000000;
        2: value = '0;
        3: value = -32'sd1;
        4: value = 32'sh55555555;
        5: value = 32'shaaaaaaaa;
        default: value = $urandom;
      endcase
      add_beat(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, value, 1'b0);
    end
    add_beat(CMD_PUSH_BACK, 32'sd1234, 1'b0);
    add_beat(CMD_PUSH_FRONT, -32'sd1234, 1'b0);

    // Random: segments that lean toward filling, draining or a balanced mix.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        seg_mode = $urandom_range(0, 2);
      end
      seg_left--;
      if ($urandom_range(0, 99) < 8) begin
        op = 3'($urandom_range(CMD_QUERY, CMD_UNUSED_LAST));
      end else begin
        push_pct = (seg_mode == 0) ? 75 : (seg_mode == 1) ? 25 : 50;
        if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else
          op = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
      end
      pick = $urandom_range(0, 9);
      case (pick)
        0: value = 32'sh7fffffff;
        1: value = 32'sh80000000;
        2: value = -32'sd1;
        3: value = '0;
        default: value = $urandom;
      endcase
      add_beat(op, value, i == DRAIN_BEAT);
    end
    beats_total = pending_beats.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_sent < beats_total) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
